FILE: hw/rtl/command_packet_framer_top_defines.svh
// ----------------------------------------------------------------------------
// Command packet framer assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMMAND_PACKET_FRAMER_TOP_DEFINES_SVH
`define COMMAND_PACKET_FRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
`define CPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("command packet framer check failed");
`define CPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("command packet framer check failed");
`else
`define CPF_ASSERT_SAME(label, clk, rst, ante, cons)
`define CPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/cpf_pkg.sv
// ----------------------------------------------------------------------------
// Command packet framer package
// Shared constants, item and frame types.
// ----------------------------------------------------------------------------
package cpf_pkg;

   localparam logic [7:0] START_BYTE  = 8'hFF;
   localparam logic [7:0] EXT_CLASS   = 8'hFF;
   localparam logic [7:0] EXT_LEN_ADD = 8'd2;

   localparam int MAX_BYTES = 6;
   localparam int IDX_W     = 3;

   typedef enum logic {
      CMD_HEADER = 1'b0,
      CMD_PARAM  = 1'b1
   } cmd_type;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic     cmd;
      byte_type device_class;
      byte_type device_id;
      byte_type param_count;
      byte_type instruction;
      byte_type param_byte;
   } req_item_type;

   typedef struct packed {
      byte_type [MAX_BYTES-1:0] bytes;
      logic [IDX_W-1:0]         count;
      logic                     ends;
   } frame_type;

endpackage

FILE: hw/rtl/cpf_req_if.sv
// ----------------------------------------------------------------------------
// Command packet framer request channel
// Valid/ready channel carrying one command item per transaction.
// ----------------------------------------------------------------------------
interface cpf_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] device_class;
   logic [7:0] device_id;
   logic [7:0] param_count;
   logic [7:0] instruction;
   logic [7:0] param_byte;

   modport source (
      output valid, cmd, device_class, device_id, param_count, instruction, param_byte,
      input  ready
   );
   modport sink (
      input  valid, cmd, device_class, device_id, param_count, instruction, param_byte,
      output ready
   );
endinterface

FILE: hw/rtl/cpf_rsp_if.sv
// ----------------------------------------------------------------------------
// Command packet framer response channel
// Valid/ready channel carrying one packet byte per transaction.
// ----------------------------------------------------------------------------
interface cpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (
      output valid, out_byte, last,
      input  ready
   );
   modport sink (
      input  valid, out_byte, last,
      output ready
   );
endinterface

FILE: hw/rtl/cpf_frame_gen.sv
// ----------------------------------------------------------------------------
// Command packet framer frame generator
// Holds packet state and builds the bytes one item contributes.
// ----------------------------------------------------------------------------
module cpf_frame_gen (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  cpf_pkg::req_item_type item,
   output cpf_pkg::frame_type   frame
);

   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] params_left_ff, params_left_in;
   logic       invert_sum_ff,  invert_sum_in;
   logic       in_packet_ff,   in_packet_in;

   logic       ext;
   logic [7:0] len;
   logic [7:0] hdr_sum;
   logic [7:0] par_sum;
   logic [7:0] left_dec;

   always_comb begin
      ext      = (item.device_class == cpf_pkg::EXT_CLASS);
      len      = ext ? item.param_count + cpf_pkg::EXT_LEN_ADD : item.param_count;
      hdr_sum  = item.device_id + len + item.instruction;
      par_sum  = running_sum_ff + item.param_byte;
      left_dec = params_left_ff - 8'd1;

      frame          = '0;
      running_sum_in = running_sum_ff;
      params_left_in = params_left_ff;
      invert_sum_in  = invert_sum_ff;
      in_packet_in   = in_packet_ff;

      if (item.cmd == cpf_pkg::CMD_HEADER) begin
         frame.bytes[0] = cpf_pkg::START_BYTE;
         frame.bytes[1] = item.device_class;
         frame.bytes[2] = item.device_id;
         frame.bytes[3] = len;
         frame.bytes[4] = item.instruction;
         frame.bytes[5] = ext ? ~hdr_sum : hdr_sum;
         running_sum_in = hdr_sum;
         params_left_in = item.param_count;
         invert_sum_in  = ext;
         if (item.param_count == 8'd0) begin
            frame.count  = cpf_pkg::IDX_W'(6);
            frame.ends   = 1'b1;
            in_packet_in = 1'b0;
         end else begin
            frame.count  = cpf_pkg::IDX_W'(5);
            in_packet_in = 1'b1;
         end
      end else if (in_packet_ff) begin
         frame.bytes[0] = item.param_byte;
         frame.bytes[1] = invert_sum_ff ? ~par_sum : par_sum;
         running_sum_in = par_sum;
         params_left_in = left_dec;
         if (left_dec == 8'd0) begin
            frame.count  = cpf_pkg::IDX_W'(2);
            frame.ends   = 1'b1;
            in_packet_in = 1'b0;
         end else begin
            frame.count  = cpf_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
         params_left_ff <= '0;
         invert_sum_ff  <= 1'b0;
         in_packet_ff   <= 1'b0;
      end else if (accept) begin
         running_sum_ff <= running_sum_in;
         params_left_ff <= params_left_in;
         invert_sum_ff  <= invert_sum_in;
         in_packet_ff   <= in_packet_in;
      end
   end

endmodule

FILE: hw/rtl/command_packet_framer_top.sv
// ----------------------------------------------------------------------------
// Command packet framer
// Turns header and parameter items into a framed, checksummed byte stream.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  req_ch   | in  | one item: header (cmd 0) or parameter byte (cmd 1)
//  rsp_ch   | out | one packet byte, last set on the checksum
//
//  A header yields 5 or 6 bytes, a parameter 1 or 2, a stray parameter none.
//  Bytes leave one per cycle from the frame buffer; the next item is taken
//  in the cycle the final buffered byte is taken, so items flow gap-free.
//  Synchronous active-high reset empties the buffer and closes any packet.
//  A stall on rsp_ch holds the current byte and back-pressures req_ch.
`include "command_packet_framer_top_defines.svh"

module command_packet_framer_top (
   input logic     clock,
   input logic     reset,
   cpf_req_if.sink   req_ch,
   cpf_rsp_if.source rsp_ch
);

   cpf_pkg::req_item_type item;
   cpf_pkg::frame_type    frame;
   cpf_pkg::frame_type    buf_ff;

   logic                       buf_valid_ff;
   logic [cpf_pkg::IDX_W-1:0]  idx_ff;
   logic                       at_end;
   logic                       rsp_take;
   logic                       drain;
   logic                       accept;

   always_comb begin
      item.cmd          = req_ch.cmd;
      item.device_class = req_ch.device_class;
      item.device_id    = req_ch.device_id;
      item.param_count  = req_ch.param_count;
      item.instruction  = req_ch.instruction;
      item.param_byte   = req_ch.param_byte;
   end

   assign at_end       = (idx_ff == buf_ff.count - cpf_pkg::IDX_W'(1));
   assign rsp_take     = buf_valid_ff && rsp_ch.ready;
   assign drain        = rsp_take && at_end;
   assign req_ch.ready = !buf_valid_ff || drain;
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid    = buf_valid_ff;
   assign rsp_ch.out_byte = buf_ff.bytes[idx_ff];
   assign rsp_ch.last     = buf_ff.ends && at_end;

   cpf_frame_gen u_frame_gen (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .frame  (frame)
   );

   always_ff @(posedge clock) begin
      if (accept && frame.count != '0) begin
         buf_ff <= frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (accept && frame.count != '0) begin
         buf_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (drain) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (rsp_take) begin
         idx_ff <= idx_ff + cpf_pkg::IDX_W'(1);
      end
   end

   `CPF_ASSERT_SAME(a_idx_in_frame, clock, reset, buf_valid_ff, idx_ff < buf_ff.count)
   `CPF_ASSERT_SAME(a_accept_only_drained, clock, reset, accept && buf_valid_ff, drain)
   `CPF_ASSERT_NEXT(a_last_closes, clock, reset, rsp_take && rsp_ch.last && !accept, !buf_valid_ff)

endmodule
